>>> rtl/gifp_pkg.sv
// ============================================================================
// GIF code packer package
// Shared constants and the code word handed from the packer to the serializer.
// ============================================================================
package gifp_pkg;

    // Configuration register: GIF minimum code size
    localparam int unsigned CODE_SIZE_W = 4;
    localparam logic [CODE_SIZE_W-1:0] CODE_SIZE_RESET = 4'd8;
    localparam logic [CODE_SIZE_W-1:0] CODE_SIZE_MIN   = 4'd2;
    localparam logic [CODE_SIZE_W-1:0] CODE_SIZE_MAX   = 4'd8;

    // Field widths
    localparam int unsigned PIXEL_W = 8;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned FILL_W  = 8;

    // Widest code (b = 8) and the bit assembly area for one pixel
    localparam int unsigned CODE_W  = 9;
    localparam int unsigned ACC_W   = 56;
    localparam int unsigned POS_W   = 6;
    localparam int unsigned PAD_BITS = 7;

    // At most five bytes leave for one pixel: seven leftover bits, one clear
    // code, the pixel code, the end code and the padding make 41 bits.
    localparam int unsigned WORD_BYTES = 5;
    localparam int unsigned WORD_W     = WORD_BYTES * BYTE_W;
    localparam int unsigned NBYTES_W   = 3;

    // Default sub-block size
    localparam int unsigned SUBBLOCK_BYTES_DEFAULT = 255;

    // Code bits of one pixel, ready to be sent out byte by byte
    typedef struct packed {
        logic [WORD_W-1:0]   bits;
        logic [NBYTES_W-1:0] nbytes;
        logic                last;
    } gifp_word_t;

endpackage

>>> rtl/gifp_packer.sv
// ============================================================================
// GIF code packer: bit assembly stage
// Builds the clear, pixel and end codes of one pixel, LSB-first, on top of the
// bits left over from the previous pixel, and registers the whole bytes.
// ============================================================================
module gifp_packer
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [gifp_pkg::CODE_SIZE_W-1:0]   min_code_bits,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [gifp_pkg::PIXEL_W-1:0]       s_axis_tdata,
    input  logic                               s_axis_tlast,
    output logic                               word_valid,
    input  logic                               word_ready,
    output gifp_pkg::gifp_word_t               word
);

    // Running stream state
    logic [gifp_pkg::BYTE_W-1:0]   left_reg, left_next;
    logic [2:0]                    left_cnt_reg, left_cnt_next;
    logic [gifp_pkg::FILL_W-1:0]   clr_cnt_reg, clr_cnt_next;

    // Output word register
    logic                          pend_valid_reg, pend_valid_next;
    gifp_pkg::gifp_word_t          pend_reg, pend_next;

    // Code size derived values
    logic [gifp_pkg::CODE_SIZE_W-1:0] b;
    logic [gifp_pkg::CODE_SIZE_W-1:0] w;
    logic [gifp_pkg::CODE_W-1:0]      clear_code;
    logic [gifp_pkg::CODE_W-1:0]      eoi_code;
    logic [gifp_pkg::CODE_W-1:0]      mask;
    logic [gifp_pkg::FILL_W-1:0]      limit;

    // Clear countdown
    logic [gifp_pkg::FILL_W-1:0]   cnt1, cnt_a, cnt2;
    logic                          clr1, clr2;

    // Bit assembly
    logic [gifp_pkg::ACC_W-1:0]    acc;
    logic [gifp_pkg::ACC_W-1:0]    tail;
    logic [gifp_pkg::POS_W-1:0]    pos;
    logic [gifp_pkg::NBYTES_W-1:0] nbytes;

    logic accept;

    assign s_axis_tready = !pend_valid_reg || word_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Clamp the code size and derive the special codes.
    always_comb
    begin
        b = min_code_bits;
        if (b < gifp_pkg::CODE_SIZE_MIN)
        begin
            b = gifp_pkg::CODE_SIZE_MIN;
        end
        if (b > gifp_pkg::CODE_SIZE_MAX)
        begin
            b = gifp_pkg::CODE_SIZE_MAX;
        end
        w          = b + 4'd1;
        clear_code = 9'd1 << b;
        eoi_code   = clear_code + 9'd1;
        mask       = clear_code - 9'd1;
        limit      = gifp_pkg::FILL_W'(clear_code - 9'd2);
    end

    // A clear code is due when the countdown reaches zero; the end code of the
    // last pixel counts as a second code.
    always_comb
    begin
        cnt1  = clr_cnt_reg - 8'd1;
        clr1  = (cnt1 == '0);
        cnt_a = clr1 ? limit : cnt1;
        cnt2  = cnt_a - 8'd1;
        clr2  = (cnt2 == '0);
    end

    // Place the codes one after the other above the leftover bits.
    always_comb
    begin
        acc = gifp_pkg::ACC_W'(left_reg);
        pos = {3'b000, left_cnt_reg};
        if (clr1)
        begin
            acc = acc | (gifp_pkg::ACC_W'(clear_code) << pos);
            pos = pos + {2'b00, w};
        end
        acc = acc | (gifp_pkg::ACC_W'(s_axis_tdata & mask[gifp_pkg::PIXEL_W-1:0]) << pos);
        pos = pos + {2'b00, w};
        if (s_axis_tlast)
        begin
            if (clr2)
            begin
                acc = acc | (gifp_pkg::ACC_W'(clear_code) << pos);
                pos = pos + {2'b00, w};
            end
            acc = acc | (gifp_pkg::ACC_W'(eoi_code) << pos);
            pos = pos + {2'b00, w} + gifp_pkg::POS_W'(gifp_pkg::PAD_BITS);
        end
        nbytes = pos[gifp_pkg::POS_W-1:3];
        tail   = acc >> {nbytes, 3'b000};
    end

    // Next state of the stream and of the word register.
    always_comb
    begin
        left_next       = left_reg;
        left_cnt_next   = left_cnt_reg;
        clr_cnt_next    = clr_cnt_reg;
        pend_valid_next = pend_valid_reg && !word_ready;
        pend_next       = pend_reg;
        if (accept)
        begin
            if (s_axis_tlast)
            begin
                left_next     = '0;
                left_cnt_next = '0;
                clr_cnt_next  = 8'd1;
            end
            else
            begin
                left_next     = tail[gifp_pkg::BYTE_W-1:0];
                left_cnt_next = pos[2:0];
                clr_cnt_next  = cnt_a;
            end
            pend_valid_next = (nbytes != '0);
            pend_next.bits   = acc[gifp_pkg::WORD_W-1:0];
            pend_next.nbytes = nbytes;
            pend_next.last   = s_axis_tlast;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg       <= '0;
            left_cnt_reg   <= '0;
            clr_cnt_reg    <= 8'd1;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            left_reg       <= left_next;
            left_cnt_reg   <= left_cnt_next;
            clr_cnt_reg    <= clr_cnt_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

    assign word_valid = pend_valid_reg;
    assign word       = pend_reg;

endmodule

>>> rtl/gifp_serializer.sv
// ============================================================================
// GIF code packer: byte serializer
// Sends the bytes of each code word one per cycle while m_axis_tready is high, and
// marks sub-block ends and the end of the image.
// ============================================================================
module gifp_serializer
#(
    parameter int unsigned SUBBLOCK_BYTES = gifp_pkg::SUBBLOCK_BYTES_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  word_valid,
    output logic                  word_ready,
    input  gifp_pkg::gifp_word_t  word,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [15:0]           m_axis_tdata,   // out_byte[7:0], block_length[15:8]
    output logic                  m_axis_tuser,   // closes_block
    output logic                  m_axis_tlast    // image_done
);

    localparam logic [gifp_pkg::FILL_W-1:0] SUB_LEN = gifp_pkg::FILL_W'(SUBBLOCK_BYTES);

    logic [gifp_pkg::WORD_W-1:0]   sh_reg, sh_next;
    logic [gifp_pkg::NBYTES_W-1:0] cnt_reg, cnt_next;
    logic                          last_reg, last_next;
    logic [gifp_pkg::FILL_W-1:0]   fill_reg, fill_next;

    logic                          take;
    logic                          final_byte;
    logic                          closes;
    logic [gifp_pkg::FILL_W-1:0]   fill_inc;

    assign m_axis_tvalid = (cnt_reg != '0);
    assign take          = m_axis_tvalid && m_axis_tready;
    assign word_ready    = (cnt_reg == '0) || ((cnt_reg == 3'd1) && m_axis_tready);

    // Sub-block bookkeeping for the byte on the output.
    always_comb
    begin
        fill_inc   = fill_reg + 8'd1;
        final_byte = last_reg && (cnt_reg == 3'd1);
        closes     = (fill_inc >= SUB_LEN) || final_byte;
    end

    assign m_axis_tdata = {closes ? fill_inc : 8'd0, sh_reg[gifp_pkg::BYTE_W-1:0]};
    assign m_axis_tuser = closes;
    assign m_axis_tlast = final_byte;

    // Shift out one byte per handshake and load the next word when empty or as the last byte is taken.
    always_comb
    begin
        sh_next   = sh_reg;
        cnt_next  = cnt_reg;
        last_next = last_reg;
        fill_next = fill_reg;
        if (take)
        begin
            sh_next   = sh_reg >> gifp_pkg::BYTE_W;
            cnt_next  = cnt_reg - 3'd1;
            fill_next = closes ? '0 : fill_inc;
        end
        if (word_ready && word_valid)
        begin
            sh_next   = word.bits;
            cnt_next  = word.nbytes;
            last_next = word.last;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            last_reg <= 1'b0;
            fill_reg <= '0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            last_reg <= last_next;
            fill_reg <= fill_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        sh_reg <= sh_next;
    end

endmodule

>>> rtl/gif_uncompressed_code_packer.sv
// ============================================================================
// GIF uncompressed code packer
// Turns palette index pixels into a GIF code stream of literal, clear and end codes only.
// ============================================================================
// Output: a pixel's first byte is offered in the cycle after the serializer accepts
// the pixel's word. Throughput: one output byte per cycle while m_axis_tready is high;
// the single byte-wide output port bounds the pixel rate (up to five bytes on the
// last pixel).
// Reset: asynchronous, active low; code size returns to 8, stream state to start.
module gif_uncompressed_code_packer
#(
    parameter int unsigned SUBBLOCK_BYTES = gifp_pkg::SUBBLOCK_BYTES_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [gifp_pkg::CODE_SIZE_W-1:0]  cfg_wdata,      // min_code_bits
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,   // pixel[7:0]
    input  logic                              s_axis_tlast,   // last_pixel
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [15:0]                       m_axis_tdata,   // out_byte[7:0], block_length[15:8]
    output logic                              m_axis_tuser,   // closes_block
    output logic                              m_axis_tlast    // image_done
);

    logic [gifp_pkg::CODE_SIZE_W-1:0] code_size_reg;
    logic                             word_valid;
    logic                             word_ready;
    gifp_pkg::gifp_word_t             word;

    // Minimum code size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_size_reg <= gifp_pkg::CODE_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            code_size_reg <= cfg_wdata;
        end
    end

    // Code assembly
    gifp_packer u_packer
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .min_code_bits (code_size_reg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .word_valid    (word_valid),
        .word_ready    (word_ready),
        .word          (word)
    );

    // Byte output
    gifp_serializer #(
        .SUBBLOCK_BYTES (SUBBLOCK_BYTES)
    ) u_serializer
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .word_valid    (word_valid),
        .word_ready    (word_ready),
        .word          (word),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // The final byte of an image always closes its sub-block.
    a_done_closes: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
        else $error("image end without sub-block close");

    // A closing byte carries a nonzero length, any other byte a zero length.
    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[15:8] != 8'd0)
        else $error("sub-block closed with zero length");

    a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[15:8] == 8'd0)
        else $error("length reported on a byte that does not close a sub-block");

    // After the image ends, the next byte starts a fresh sub-block.
    a_fresh_block: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast ##1 m_axis_tvalid && m_axis_tuser
        |-> m_axis_tdata[15:8] == 8'd1 || m_axis_tlast || SUBBLOCK_BYTES == 1)
        else $error("sub-block count not restarted after image end");

endmodule
